@@ hdl/bsc_pkg.sv @@
// Shared types, constants and widths for the barometer sample compensation block.
// Used by bsc_cfg, bsc_mul and baro_sample_compensation; depends on nothing.
`default_nettype none

package bsc_pkg;

  // Field and register widths.
  localparam int unsigned CoefW   = 16;
  localparam int unsigned RawW    = 24;
  localparam int unsigned PresW   = 24;
  localparam int unsigned TempW   = 19;
  localparam int unsigned DtW     = 26;
  localparam int unsigned CfgIdxW = 3;

  // Serial multiplier: signed multiplicand, unsigned multiplier, full product.
  localparam int unsigned MulAW   = 40;
  localparam int unsigned MulBW   = 24;
  localparam int unsigned MulPW   = 64;
  localparam int unsigned MulCntW = $clog2(MulBW + 1);

  // Working widths of the pressure path.
  localparam int unsigned OffW    = 40;
  localparam int unsigned DiffW   = 41;

  // Compensation constants.
  localparam int unsigned TempBaseScaled = 64000;  // 2000 hundredths times 32
  localparam int unsigned TShift     = 18;
  localparam int unsigned OffCShift  = 16;
  localparam int unsigned SensCShift = 15;
  localparam int unsigned OffTShift  = 7;
  localparam int unsigned SensTShift = 8;
  localparam int unsigned SensShift  = 21;
  localparam int unsigned PShift     = 10;
  localparam int unsigned XpShift    = 5;

  // Input kinds.
  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRES = 1'b1;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] IDX_SENS      = 3'd0;
  localparam logic [CfgIdxW-1:0] IDX_OFFSET    = 3'd1;
  localparam logic [CfgIdxW-1:0] IDX_SENS_TC   = 3'd2;
  localparam logic [CfgIdxW-1:0] IDX_OFFSET_TC = 3'd3;
  localparam logic [CfgIdxW-1:0] IDX_REF_TEMP  = 3'd4;
  localparam logic [CfgIdxW-1:0] IDX_TEMP_SENS = 3'd5;

  // Multiplier bit counts for the two operand kinds.
  localparam logic [MulCntW-1:0] NBITS_COEF = MulCntW'(CoefW);
  localparam logic [MulCntW-1:0] NBITS_RAW  = MulCntW'(RawW);

  // The six calibration words.
  typedef struct packed {
    logic [CoefW-1:0] sens;
    logic [CoefW-1:0] offset;
    logic [CoefW-1:0] sens_tc;
    logic [CoefW-1:0] offset_tc;
    logic [CoefW-1:0] ref_temp;
    logic [CoefW-1:0] temp_sens;
  } coef_t;

  // Request to the serial multiplier.
  typedef struct packed {
    logic               start;
    logic [MulCntW-1:0] nbits;
  } mul_req_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_TMUL,
    S_OMUL,
    S_SMUL,
    S_PMUL,
    S_PFIN,
    S_OUT
  } bsc_state_e;

endpackage

`default_nettype wire

@@ hdl/bsc_cfg.sv @@
// Calibration word register file for the barometer sample compensation block.
// Depends on bsc_pkg for the register indexes and the coef_t struct.
`default_nettype none

module bsc_cfg import bsc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CoefW-1:0]   cfg_data_i,
  output coef_t                   coef_o
);

  coef_t coef_q;

  // Write one word per enabled cycle; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        IDX_SENS:      coef_q.sens      <= cfg_data_i;
        IDX_OFFSET:    coef_q.offset    <= cfg_data_i;
        IDX_SENS_TC:   coef_q.sens_tc   <= cfg_data_i;
        IDX_OFFSET_TC: coef_q.offset_tc <= cfg_data_i;
        IDX_REF_TEMP:  coef_q.ref_temp  <= cfg_data_i;
        IDX_TEMP_SENS: coef_q.temp_sens <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

@@ hdl/bsc_mul.sv @@
// Bit-serial shift-and-add multiplier: signed multiplicand, unsigned multiplier.
// Depends on bsc_pkg for the mul_req_t request struct.
`default_nettype none

module bsc_mul import bsc_pkg::*; #(
  parameter int unsigned AW = MulAW,
  parameter int unsigned BW = MulBW,
  parameter int unsigned PW = MulPW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mul_req_t             req_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic        [BW-1:0] b_i,
  output logic                      done_o,
  output logic signed [PW-1:0]      p_o
);

  logic                busy_q;
  logic                done_q;
  logic [MulCntW-1:0]  cnt_q;
  logic signed [PW-1:0] mcand_q;
  logic        [BW-1:0] mplier_q;
  logic signed [PW-1:0] acc_q;

  // Control: count down one multiplier bit per cycle, pulse done at the end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MulCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand when the low multiplier bit is set.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q  <= PW'(a_i);
      mplier_q <= b_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

`default_nettype wire

@@ hdl/baro_sample_compensation.sv @@
// Top level of the barometer sample compensation block: sequencer and datapath.
// Depends on bsc_pkg, bsc_cfg and bsc_mul.
//
//   Channel  Signals                       Words
//   s_axis   tvalid tready tdata tuser     raw conversion in, tuser = opcode
//   m_axis   tvalid tready tdata tuser     pressure and temperature out
//   cfg      cfg_we_i cfg_idx_i cfg_data_i calibration word writes
//
// A temperature word takes one multiplication (dT*C6) and a pressure word three
// (offset, sensitivity and pressure products), all on the shared bit-serial
// multiplier, one multiplier bit per cycle (16 bits for a calibration word, 24
// for the raw sample).
// Reset clears the calibration words, the kept difference and temperatures.
// A new word is taken once the previous one has reached the output register;
// a stalled output holds the sequencer in its final state.
`default_nettype none

module baro_sample_compensation import bsc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input words.
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [RawW-1:0]    s_axis_tdata,   // raw_sample[23:0]
  input  wire logic               s_axis_tuser,   // opcode
  // Result words.
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [47:0]             m_axis_tdata,   // pressure_out[23:0], temperature_out[42:24]
  output logic                    m_axis_tuser,   // updated
  // Configuration writes.
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CoefW-1:0]   cfg_data_i
);

  coef_t      coef;
  mul_req_t   mul_req;
  logic signed [MulAW-1:0] mul_a;
  logic        [MulBW-1:0] mul_b;
  logic                    mul_done;
  logic signed [MulPW-1:0] mul_p;

  bsc_state_e state_q, state_d;

  logic signed [DtW-1:0]   dt_q, dt_d;
  logic signed [TempW-1:0] pend_q, pend_d;
  logic signed [PresW-1:0] shown_p_q, shown_p_d;
  logic signed [TempW-1:0] shown_t_q, shown_t_d;
  logic                    upd_q, upd_d;
  logic        [RawW-1:0]  raw_q, raw_d;
  logic signed [OffW-1:0]  off_q, off_d;
  logic signed [DiffW-1:0] diff_q, diff_d;

  logic                    out_valid_q, out_valid_d;
  logic signed [PresW-1:0] out_p_q;
  logic signed [TempW-1:0] out_t_q;
  logic                    out_u_q;
  logic                    out_load;

  logic signed [DtW-1:0]   dt_in;
  logic signed [24:0]      t_scaled;
  logic signed [25:0]      t_sum;
  logic signed [25:0]      t_adj;
  logic signed [TempW-1:0] pend_new;
  logic signed [OffW-1:0]  off_new;
  logic signed [MulAW-1:0] sens_new;
  logic signed [DiffW-1:0] diff_new;
  logic signed [30:0]      p_shr;
  logic signed [30:0]      p_adj;
  logic signed [PresW-1:0] pres_new;

  bsc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coef_o     (coef)
  );

  bsc_mul #(
    .AW (MulAW),
    .BW (MulBW),
    .PW (MulPW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  // Temperature difference against the reference reading.
  assign dt_in = $signed({2'b00, s_axis_tdata})
               - $signed({2'b00, coef.ref_temp, 8'h00});

  // Pending temperature: (64000 + (dT*C6 >>> 18)) / 32, truncated toward zero.
  assign t_scaled = 25'(mul_p >>> TShift);
  assign t_sum    = {t_scaled[24], t_scaled} + 26'(TempBaseScaled);
  assign t_adj    = t_sum[25] ? (t_sum + 26'sd31) : t_sum;
  assign pend_new = TempW'(t_adj >>> XpShift);

  // Offset and sensitivity from the temperature-coefficient products.
  assign off_new  = $signed({{(OffW-CoefW-OffCShift){1'b0}}, coef.offset, 16'h0000})
                  + OffW'(mul_p >>> OffTShift);
  assign sens_new = $signed({{(MulAW-CoefW-SensCShift){1'b0}}, coef.sens, 15'h0000})
                  + MulAW'(mul_p >>> SensTShift);

  // Pressure: ((raw*sens >>> 21) - off) >>> 10, then / 32 toward zero.
  assign diff_new = DiffW'(mul_p >>> SensShift) - DiffW'(off_q);
  assign p_shr    = 31'(diff_q >>> PShift);
  assign p_adj    = p_shr[30] ? (p_shr + 31'sd31) : p_shr;
  assign pres_new = PresW'(p_adj >>> XpShift);

  assign out_load = !out_valid_q || m_axis_tready;

  // Sequencer state register and kept state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dt_q        <= '0;
      pend_q      <= '0;
      shown_p_q   <= '0;
      shown_t_q   <= '0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dt_q        <= dt_d;
      pend_q      <= pend_d;
      shown_p_q   <= shown_p_d;
      shown_t_q   <= shown_t_d;
      upd_q       <= upd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers of the pressure path.
  always_ff @(posedge clk_i) begin
    raw_q  <= raw_d;
    off_q  <= off_d;
    diff_q <= diff_d;
  end

  // Output register, loaded when the sequencer finishes a word.
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_load) begin
      out_p_q <= shown_p_q;
      out_t_q <= shown_t_q;
      out_u_q <= upd_q;
    end
  end

  // Next state, multiplier requests and datapath updates.
  always_comb begin
    state_d       = state_q;
    dt_d          = dt_q;
    pend_d        = pend_q;
    shown_p_d     = shown_p_q;
    shown_t_d     = shown_t_q;
    upd_d         = upd_q;
    raw_d         = raw_q;
    off_d         = off_q;
    diff_d        = diff_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    mul_req.start = 1'b0;
    mul_req.nbits = NBITS_COEF;
    mul_a         = MulAW'(dt_q);
    mul_b         = MulBW'(coef.offset_tc);
    s_axis_tready = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          mul_req.start = 1'b1;
          if (s_axis_tuser == OP_TEMP) begin
            dt_d    = dt_in;
            mul_a   = MulAW'(dt_in);
            mul_b   = MulBW'(coef.temp_sens);
            state_d = S_TMUL;
          end else begin
            raw_d   = s_axis_tdata;
            state_d = S_OMUL;
          end
        end
      end
      S_TMUL: begin
        if (mul_done) begin
          pend_d  = pend_new;
          upd_d   = 1'b0;
          state_d = S_OUT;
        end
      end
      S_OMUL: begin
        if (mul_done) begin
          off_d         = off_new;
          mul_req.start = 1'b1;
          mul_b         = MulBW'(coef.sens_tc);
          state_d       = S_SMUL;
        end
      end
      S_SMUL: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.nbits = NBITS_RAW;
          mul_a         = sens_new;
          mul_b         = raw_q;
          state_d       = S_PMUL;
        end
      end
      S_PMUL: begin
        if (mul_done) begin
          diff_d  = diff_new;
          state_d = S_PFIN;
        end
      end
      S_PFIN: begin
        shown_p_d = pres_new;
        shown_t_d = pend_q;
        upd_d     = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_t_q, out_p_q};
  assign m_axis_tuser  = out_u_q;

endmodule

`default_nettype wire
